@@ sv/printf_to_brace_format_converter_core_assert.svh @@
// Assertion macros for the printf to brace format converter.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef PRINTF_TO_BRACE_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define PRINTF_TO_BRACE_FORMAT_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define P2B_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p2b assertion failed");
// next-cycle implication
`define P2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p2b assertion failed");
`else
`define P2B_ASSERT(lbl, clk, rst_n, ante, cons)
`define P2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/p2b_pkg.sv @@
// Shared types and constants for the printf to brace format converter.
// No dependencies.
`timescale 1ns / 1ps
package p2b_pkg;

	// scan mode codes
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_PCT   = 2'd1;
	localparam logic [1:0] MODE_FLAG  = 2'd2;
	localparam logic [1:0] MODE_WIDTH = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_PCT    = 8'h25; // '%'
	localparam logic [7:0] CH_LBRACE = 8'h7B; // '{'
	localparam logic [7:0] CH_RBRACE = 8'h7D; // '}'
	localparam logic [7:0] CH_COLON  = 8'h3A; // ':'
	localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
	localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
	localparam logic [7:0] CH_SPACE  = 8'h20; // ' '
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'

	localparam int MAX_OUT = 4;

	// expansion of one input byte
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] chars;     // output bytes, first in entry 0
		logic [2:0]              cnt;       // number of valid bytes, 0..4
		logic [1:0]              next_mode; // scan mode after this byte
	} p2b_exp_t;

endpackage

@@ sv/p2b_decode.sv @@
// Combinational expansion of one format-string byte into up to four output bytes.
// Depends on p2b_pkg.
`timescale 1ns / 1ps
module p2b_decode (
	input  logic [1:0]        scan_mode,
	input  logic [7:0]        in_char,
	input  logic              in_final,
	output p2b_pkg::p2b_exp_t expn
);
	import p2b_pkg::*;

	logic is_flag;
	logic is_digit;
	logic [MAX_OUT-1:0][7:0] chars;
	logic [2:0] n;
	logic [1:0] nxt;

	assign is_flag  = in_char inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_ZERO};
	assign is_digit = in_char inside {[CH_ZERO:CH_NINE]};

	// expansion per scan mode, then close an open field on the final byte
	always_comb begin
		chars = '0;
		n     = 3'd0;
		nxt   = MODE_PLAIN;
		case (scan_mode)
			MODE_PLAIN: begin
				if (in_char == CH_PCT) begin
					if (in_final) begin
						chars[0] = CH_PCT;
						n        = 3'd1;
					end else begin
						nxt = MODE_PCT;
					end
				end else if (in_char inside {CH_LBRACE, CH_RBRACE}) begin
					chars[0] = in_char;
					chars[1] = in_char;
					n        = 3'd2;
				end else begin
					chars[0] = in_char;
					n        = 3'd1;
				end
			end
			MODE_PCT: begin
				if (in_char == CH_PCT) begin
					chars[0] = CH_PCT;
					n        = 3'd1;
				end else begin
					chars[0] = CH_LBRACE;
					chars[1] = CH_COLON;
					chars[2] = in_char;
					n        = 3'd3;
					if (is_flag) begin
						nxt = MODE_FLAG;
					end else if (is_digit) begin
						nxt = MODE_WIDTH;
					end else begin
						chars[3] = CH_RBRACE;
						n        = 3'd4;
					end
				end
			end
			MODE_FLAG: begin
				chars[0] = in_char;
				n        = 3'd1;
				if (is_digit) begin
					nxt = MODE_WIDTH;
				end else begin
					chars[1] = CH_RBRACE;
					n        = 3'd2;
				end
			end
			default: begin
				chars[0] = in_char;
				chars[1] = CH_RBRACE;
				n        = 3'd2;
			end
		endcase
		// string ends inside a field: close it (n is at most 3 here)
		if (in_final && nxt != MODE_PLAIN) begin
			chars[n[1:0]] = CH_RBRACE;
			n             = n + 3'd1;
			nxt           = MODE_PLAIN;
		end
	end

	assign expn.chars     = chars;
	assign expn.cnt       = n;
	assign expn.next_mode = nxt;

endmodule

@@ sv/printf_to_brace_format_converter_core.sv @@
// A byte accepted into the expansion buffer passes its results one at a time to the
// output register. Throughput: one output byte per cycle while m_axis_tready is high;
// an input with n results (1 to 4) holds the buffer until the single output register
// has drained it, so plain bytes stream at one per cycle unless the output stalls.
// Reset: arst_n clears scan mode and all valid flags asynchronously; output is idle.
// Top level of the printf to brace format converter; depends on p2b_pkg, p2b_decode.
`timescale 1ns / 1ps
`include "printf_to_brace_format_converter_core_assert.svh"
module printf_to_brace_format_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_char
	input  logic       s_axis_tlast,  // in_final
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_char
	output logic       m_axis_tlast,  // run_last
	output logic       m_axis_tuser   // [0] text_end
);
	import p2b_pkg::*;

	logic [1:0] mode_q;
	p2b_exp_t   expn;

	// expansion buffer
	logic                    valid_s1;
	logic [MAX_OUT-1:0][7:0] chars_s1;
	logic [2:0]              cnt_s1;
	logic [1:0]              idx_s1;
	logic                    fin_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_end_q;

	logic in_xfer;
	logic out_free;
	logic s1_move;
	logic s1_at_last;
	logic s1_done;

	p2b_decode u_decode (
		.scan_mode (mode_q),
		.in_char   (s_axis_tdata),
		.in_final  (s_axis_tlast),
		.expn      (expn)
	);

	// handshake and buffer advance
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_move       = valid_s1 && out_free;
	assign s1_at_last    = ({1'b0, idx_s1} == (cnt_s1 - 3'd1));
	assign s1_done       = s1_move && s1_at_last;
	assign s_axis_tready = !valid_s1 || s1_done;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// scan mode moves on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
		end else if (in_xfer) begin
			mode_q <= expn.next_mode;
		end
	end

	// expansion buffer control; a byte with no results never enters it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= 2'd0;
		end else if (in_xfer && expn.cnt != 3'd0) begin
			valid_s1 <= 1'b1;
			idx_s1   <= 2'd0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (s1_move) begin
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	// expansion buffer payload
	always_ff @(posedge clk) begin
		if (in_xfer && expn.cnt != 3'd0) begin
			chars_s1 <= expn.chars;
			cnt_s1   <= expn.cnt;
			fin_s1   <= s_axis_tlast;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_char_q <= chars_s1[idx_s1];
			out_last_q <= s1_at_last;
			out_end_q  <= s1_at_last && fin_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_end_q;

	// checks
	`P2B_ASSERT(a_buf_index, clk, arst_n, valid_s1, cnt_s1 != 3'd0 && {1'b0, idx_s1} < cnt_s1)
	`P2B_ASSERT(a_end_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`P2B_ASSERT_NEXT(a_final_clears_mode, clk, arst_n, in_xfer && s_axis_tlast, mode_q == MODE_PLAIN)
	`P2B_ASSERT(a_stall_needs_buf, clk, arst_n, !s_axis_tready, valid_s1)

endmodule

@@ test/tb_printf_to_brace_format_converter_core.sv @@
// Self-checking testbench for printf_to_brace_format_converter_core: a directed table
// and random format strings are streamed in, every output byte is checked in order.
// Depends on p2b_pkg and the converter RTL.
`timescale 1ns / 1ps
module tb_printf_to_brace_format_converter_core;
	import p2b_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RAND_BYTES  = 243;

	// one output byte as it should leave the block
	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       text_end;
	} brace_byte_t;

	// one row of the directed table; typed rows carry their expected bytes
	typedef struct packed {
		logic [7:0]      ch;
		logic            fin;
		logic            typed;
		logic [2:0]      n;
		logic [0:3][7:0] chars;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	brace_byte_t brace_bytes_q[$];
	stim_row_t   dir_rows[$];
	logic [1:0]  scan_state = MODE_PLAIN;
	int          mismatch_cnt = 0;
	int          stall_cycles = 0;
	int          bytes_sent = 0;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	brace_byte_t want;

	printf_to_brace_format_converter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// expansion of one format byte, advancing the scan state
	function automatic void convert_byte(input logic [7:0] ch, input logic fin,
			output logic [0:3][7:0] chars, output int n);
		logic [1:0] nxt;
		bit         flag_ch;
		bit         digit_ch;
		nxt = MODE_PLAIN;
		n = 0;
		chars = '0;
		flag_ch = ch inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_ZERO};
		digit_ch = ch inside {[CH_ZERO:CH_NINE]};
		case (scan_state)
			MODE_PLAIN: begin
				if (ch == CH_PCT) begin
					if (fin) begin
						chars[n] = CH_PCT; n++;
					end else
						nxt = MODE_PCT;
				end else begin
					if (ch inside {CH_LBRACE, CH_RBRACE}) begin
						chars[n] = ch; n++;
					end
					chars[n] = ch; n++;
				end
			end
			MODE_PCT: begin
				if (ch == CH_PCT) begin
					chars[n] = CH_PCT; n++;
				end else begin
					chars[n] = CH_LBRACE; n++;
					chars[n] = CH_COLON; n++;
					chars[n] = ch; n++;
					if (flag_ch)
						nxt = MODE_FLAG;
					else if (digit_ch)
						nxt = MODE_WIDTH;
					else begin
						chars[n] = CH_RBRACE; n++;
					end
				end
			end
			MODE_FLAG: begin
				chars[n] = ch; n++;
				if (digit_ch)
					nxt = MODE_WIDTH;
				else begin
					chars[n] = CH_RBRACE; n++;
				end
			end
			default: begin
				chars[n] = ch; n++;
				chars[n] = CH_RBRACE; n++;
			end
		endcase
		// string ends inside an open field: close it
		if (fin && nxt != MODE_PLAIN) begin
			chars[n] = CH_RBRACE; n++;
			nxt = MODE_PLAIN;
		end
		scan_state = nxt;
	endfunction

	// one input transfer; optional hold-off until the output side has drained
	task automatic send_byte(input logic [7:0] ch, input logic fin, input bit drain,
			input bit typed, input int typed_n, input logic [0:3][7:0] typed_chars);
		logic [0:3][7:0] chars;
		int              n;
		brace_byte_t     b;
		if (drain || (tx_gaps && $urandom_range(99) < 29)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (drain && brace_bytes_q.size() != 0)
				@(posedge clk);
			while (tx_gaps && $urandom_range(99) < 29)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		convert_byte(ch, fin, chars, n);
		if (typed) begin
			chars = typed_chars;
			n = typed_n;
		end
		for (int i = 0; i < n; i++) begin
			b.out_char = chars[i];
			b.run_last = (i == n - 1);
			b.text_end = (i == n - 1) && fin;
			brace_bytes_q = {brace_bytes_q, b};
		end
	endtask

	task automatic add_row(input logic [7:0] ch, input logic fin, input logic typed,
			input logic [2:0] n, input logic [0:3][7:0] chars);
		stim_row_t r;
		r.ch = ch;
		r.fin = fin;
		r.typed = typed;
		r.n = n;
		r.chars = chars;
		dir_rows = {dir_rows, r};
	endtask

	// a random format string, well formed most of the time
	task automatic send_string(input bit drain);
		logic [7:0] str_q[$];
		logic [7:0] ch;
		int         segs;
		if ($urandom_range(99) < 15) begin
			// noise: raw bytes, final flag anywhere
			segs = $urandom_range(1, 5);
			for (int i = 0; i < segs; i++)
				send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, drain && i == 0,
					1'b0, 0, '0);
			return;
		end
		segs = $urandom_range(1, 6);
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					ch = 8'($urandom_range(255));
					if (ch == CH_PCT)
						ch = "a";
					str_q = {str_q, ch};
				end
				4: str_q = {str_q, ($urandom_range(1) ? CH_LBRACE : CH_RBRACE)};
				5: str_q = {str_q, CH_PCT, CH_PCT};
				default: begin
					str_q = {str_q, CH_PCT};
					if ($urandom_range(1))
						case ($urandom_range(3))
							0: str_q = {str_q, CH_MINUS};
							1: str_q = {str_q, CH_PLUS};
							2: str_q = {str_q, CH_SPACE};
							default: str_q = {str_q, CH_ZERO};
						endcase
					if ($urandom_range(1))
						str_q = {str_q, 8'(CH_ZERO + $urandom_range(9))};
					case ($urandom_range(5))
						0: ch = "d";
						1: ch = "s";
						2: ch = "x";
						3: ch = "f";
						4: ch = $urandom_range(1) ? CH_LBRACE : CH_RBRACE;
						default: ch = 8'($urandom_range(255));
					endcase
					str_q = {str_q, ch};
				end
			endcase
		end
		// sometimes cut the string short, often inside a field
		if (str_q.size() > 1 && $urandom_range(99) < 15)
			str_q = str_q[0:$urandom_range(str_q.size() - 1)];
		foreach (str_q[i])
			send_byte(str_q[i], i == str_q.size() - 1, drain && i == 0, 1'b0, 0, '0);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_axis_tready <= !rx_gaps || ($urandom_range(99) >= 29);

	// output checking against the expected byte stream
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (brace_bytes_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected output byte %h last %b end %b", $realtime,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = brace_bytes_q.pop_front();
				if (m_axis_tdata !== want.out_char || m_axis_tlast !== want.run_last ||
						m_axis_tuser !== want.text_end) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: output mismatch: char %h/%h last %b/%b end %b/%b (exp/got)",
							$realtime, want.out_char, m_axis_tdata, want.run_last,
							m_axis_tlast, want.text_end, m_axis_tuser);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		bit first;
		// plain bytes, extremes and doubled braces
		add_row("A",       1'b0, 1'b1, 3'd1, {"A", 24'h0});
		add_row(8'h00,     1'b0, 1'b1, 3'd1, {8'h00, 24'h0});
		add_row(8'hFF,     1'b1, 1'b1, 3'd1, {8'hFF, 24'h0});
		add_row(CH_LBRACE, 1'b0, 1'b1, 3'd2, {CH_LBRACE, CH_LBRACE, 16'h0});
		add_row(CH_RBRACE, 1'b0, 1'b1, 3'd2, {CH_RBRACE, CH_RBRACE, 16'h0});
		// pending percent, then a literal percent
		add_row(CH_PCT,    1'b0, 1'b1, 3'd0, '0);
		add_row(CH_PCT,    1'b0, 1'b1, 3'd1, {CH_PCT, 24'h0});
		// bare conversion
		add_row(CH_PCT,    1'b0, 1'b1, 3'd0, '0);
		add_row("d",       1'b0, 1'b1, 3'd4, {CH_LBRACE, CH_COLON, "d", CH_RBRACE});
		// flag, width and conversion
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row(CH_MINUS,  1'b0, 1'b0, 3'd0, '0);
		add_row("5",       1'b0, 1'b0, 3'd0, '0);
		add_row("d",       1'b0, 1'b0, 3'd0, '0);
		// zero taken as a flag
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row(CH_ZERO,   1'b0, 1'b0, 3'd0, '0);
		add_row("x",       1'b0, 1'b0, 3'd0, '0);
		// width digit, then a brace as the conversion byte
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row(CH_NINE,   1'b0, 1'b0, 3'd0, '0);
		add_row(CH_LBRACE, 1'b0, 1'b0, 3'd0, '0);
		// string ends on a flag, then on a width digit
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row(CH_PLUS,   1'b1, 1'b0, 3'd0, '0);
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row("7",       1'b1, 1'b0, 3'd0, '0);
		// final lone percent
		add_row(CH_PCT,    1'b1, 1'b1, 3'd1, {CH_PCT, 24'h0});
		// space flag, string ends on the width digit
		add_row(CH_PCT,    1'b0, 1'b0, 3'd0, '0);
		add_row(CH_SPACE,  1'b0, 1'b0, 3'd0, '0);
		add_row("3",       1'b1, 1'b0, 3'd0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(dir_rows[i].ch, dir_rows[i].fin, 1'b0, dir_rows[i].typed,
				int'(dir_rows[i].n), dir_rows[i].chars);

		// random strings; a quiet stretch in the middle with no gaps on either side
		bytes_sent = 0;
		first = 1'b1;
		while (bytes_sent < RAND_BYTES) begin
			tx_gaps = !(bytes_sent >= 100 && bytes_sent < 180);
			rx_gaps = tx_gaps;
			send_string(first || $urandom_range(9) == 0);
			first = 1'b0;
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		s_axis_tvalid <= 1'b0;

		while (brace_bytes_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && brace_bytes_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
